// File: rtl/core/adc_sweep_scaler_time_binner_top_defines.svh
// Assertion macros shared by the sweep binner RTL.
// Used by files that include this header; expects clk and rst_n in scope.
`ifndef ADC_SWEEP_SCALER_TIME_BINNER_TOP_DEFINES_SVH
`define ADC_SWEEP_SCALER_TIME_BINNER_TOP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define ASTB_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("astb assertion failed");

// Next-cycle implication, off during reset.
`define ASTB_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("astb assertion failed");

`endif

// File: rtl/core/astb_pkg.sv
// Shared types and constants of the sweep scaler / time binner.
// No dependencies.
`default_nettype none
package astb_pkg;

  localparam logic [1:0] OP_SAMPLE    = 2'd0;
  localparam logic [1:0] OP_WR_CHAN   = 2'd1;
  localparam logic [1:0] OP_WR_GROUP  = 2'd2;

  localparam logic [0:0] CFG_CHANNELS_IN_SWEEP = 1'b0;
  localparam logic [0:0] CFG_SWEEP_PERIOD_US   = 1'b1;

  localparam logic signed [15:0] MISSING_COUNT = 16'sh8000;

  localparam int TIME_W    = 64;
  localparam int PERIOD_W  = 20;
  localparam int DIV_STEPS = 64;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage
`default_nettype wire

// File: rtl/core/astb_ifs.sv
// Valid/ready channel interfaces for count items and record words.
// Depends on nothing.
`default_nettype none
interface astb_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [2:0]         table_index;
  logic signed [15:0] raw_count;
  logic               block_start;
  logic [62:0]        block_time;
  logic signed [31:0] slope;
  logic signed [31:0] intercept;
  logic [2:0]         target_group;
  logic [3:0]         target_slot;
  logic [19:0]        period_us;
  logic [4:0]         slot_count;

  modport source (output valid, opcode, table_index, raw_count, block_start, block_time,
                  slope, intercept, target_group, target_slot, period_us, slot_count,
                  input ready);
  modport sink (input valid, opcode, table_index, raw_count, block_start, block_time,
                slope, intercept, target_group, target_slot, period_us, slot_count,
                output ready);
endinterface

interface astb_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         group;
  logic [3:0]         slot;
  logic signed [31:0] volts;
  logic               valid_res;
  logic [62:0]        time_tag;
  logic               last;

  modport source (output valid, group, slot, volts, valid_res, time_tag, last,
                  input ready);
  modport sink (input valid, group, slot, volts, valid_res, time_tag, last,
                output ready);
endinterface
`default_nettype wire

// File: rtl/core/astb_rem_unit.sv
// Bit-serial remainder unit: 64-bit dividend by 20-bit divisor, one bit a cycle.
// Depends on astb_pkg and the assertion header.
`default_nettype none
`include "adc_sweep_scaler_time_binner_top_defines.svh"
module astb_rem_unit
  import astb_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire div_ctl_t            ctl,
  input  wire logic [TIME_W-1:0]   dividend,
  input  wire logic [PERIOD_W-1:0] divisor,
  output div_sts_t                 sts,
  output logic [PERIOD_W-1:0]      rem
);

  logic                busy_r;
  logic                done_r;
  logic [5:0]          step_r;
  logic [TIME_W-1:0]   dvd_r;
  logic [PERIOD_W-1:0] dvs_r;
  logic [PERIOD_W-1:0] rem_r;
  logic [PERIOD_W:0]   partial;
  logic [PERIOD_W:0]   diff;
  logic                ge;

  assign partial = {rem_r, dvd_r[TIME_W-1]};
  assign ge      = partial >= {1'b0, dvs_r};
  assign diff    = partial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (ctl.start) begin
        busy_r <= 1'b1;
        step_r <= '0;
        rem_r  <= '0;
        dvd_r  <= dividend;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r  <= ge ? diff[PERIOD_W-1:0] : partial[PERIOD_W-1:0];
        dvd_r  <= {dvd_r[TIME_W-2:0], 1'b0};
        step_r <= step_r + 6'd1;
        if (step_r == 6'(DIV_STEPS - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign rem      = rem_r;

  `ASTB_ASSERT_IMP(a_start_idle, ctl.start, !busy_r)
  `ASTB_ASSERT_NXT(a_done_pulse, done_r, !done_r && !busy_r)
  `ASTB_ASSERT_IMP(a_rem_bound, done_r, rem_r < dvs_r)

endmodule
`default_nettype wire

// File: rtl/core/astb_scale.sv
// Count scaler: slope (Q16.16) times count, round to an integer, add offset, saturate.
// Three register stages; depends on nothing else.
`default_nettype none
module astb_scale (
  input  wire logic               clk,
  input  wire logic signed [31:0] slope,
  input  wire logic signed [31:0] offset,
  input  wire logic signed [15:0] count,
  output logic signed [31:0]      volts
);

  logic signed [47:0] prod_r;
  logic signed [47:0] rnd;
  logic signed [31:0] q_r;
  logic signed [32:0] sum;
  logic signed [31:0] volts_r;

  assign rnd = prod_r + 48'sd32768;
  assign sum = 33'(q_r) + 33'(offset);

  always_ff @(posedge clk) begin
    prod_r <= 48'(slope) * 48'(count);
    // floor of the biased value: round to nearest, ties up
    q_r    <= rnd[47:16];
    if (sum[32] != sum[31]) begin
      volts_r <= sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      volts_r <= sum[31:0];
    end
  end

  assign volts = volts_r;

endmodule
`default_nettype wire

// File: rtl/core/adc_sweep_scaler_time_binner_top.sv
// Top level of the sweep scaler / time binner: sequencer, tables, record memory.
// Depends on astb_pkg, astb_ifs, astb_rem_unit, astb_scale and the assertion header.
//
//  channel  dir  handshake          carries
//  in_ch    in   valid/ready        opcode, table entry fields, raw count, block time
//  out_ch   out  valid/ready        group, slot, volts, valid_res, time_tag, last
//  cfg_*    in   cfg_we only        channels_in_sweep, sweep_period_us
//
// Table writes leave the sequencer idle; a count that closes no record passes LOOK, RND,
// CHECK and WRITE. Closing a record adds EMIT_RD and EMIT_SEND per slot plus output stalls,
// ADV and NEXT to advance the end time and CLEAR over all SLOTS words to clear the record;
// a ceiling end time adds DIV_GO, DIV_WAIT on the bit-serial remainder unit, and CEIL.
// in_ch.ready is high only while idle. Reset is synchronous; no clearing pass is run.
`default_nettype none
`include "adc_sweep_scaler_time_binner_top_defines.svh"
module adc_sweep_scaler_time_binner_top
  import astb_pkg::*;
#(
  parameter int CHANNELS = 8,
  parameter int GROUPS   = 8,
  parameter int SLOTS    = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  astb_in_if.sink          in_ch,
  astb_out_if.source       out_ch,
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [19:0] cfg_data
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int AW = GW + SW;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LOOK, ST_RND, ST_CHECK, ST_EMIT_RD, ST_EMIT_SEND, ST_ADV, ST_NEXT,
    ST_DIV_GO, ST_DIV_WAIT, ST_CEIL, ST_CLEAR, ST_WRITE
  } state_t;

  state_t state_r;

  logic [3:0]          cis_r;
  logic [19:0]         sweep_per_r;
  logic [CW-1:0]       pos_r;
  logic [TIME_W-1:0]   rt_r;

  logic signed [31:0]  ch_slope_r  [CHANNELS];
  logic signed [31:0]  ch_offset_r [CHANNELS];
  logic [6:0]          ch_route_r  [CHANNELS];
  logic [TIME_W-1:0]   grp_end_r   [GROUPS];
  logic                grp_open_r  [GROUPS];
  logic [PERIOD_W-1:0] grp_per_r   [GROUPS];
  logic [4:0]          grp_slots_r [GROUPS];

  logic [32:0]         mem [2**AW];
  logic [32:0]         rd_data_r;
  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [32:0]         mem_wdata;
  logic [AW-1:0]       mem_raddr;

  logic [CW-1:0]       ch_r;
  logic signed [15:0]  count_r;
  logic [TIME_W-1:0]   t_r;
  logic [2:0]          g_r;
  logic [3:0]          slot_r;
  logic [PERIOD_W-1:0] per_r;
  logic [TIME_W-1:0]   end_r;
  logic [TIME_W-1:0]   tag_r;
  logic [4:0]          cnt_r;
  logic [4:0]          k_r;

  logic                in_acc;
  logic [5:0]          nch;
  logic [CW-1:0]       pos0;
  logic [5:0]          pos1;
  logic                wrap;
  logic [TIME_W-1:0]   t_now;
  logic [5:0]          idx_ext;
  logic [4:0]          g_ext;
  logic [GW-1:0]       gi;
  logic [4:0]          slot_ext;
  logic                slot_ok;
  logic [4:0]          sc_clamp;
  logic [PERIOD_W-1:0] per_clamp;
  logic                k_last;
  logic signed [31:0]  volts;

  div_ctl_t            div_ctl;
  div_sts_t            div_sts;
  logic [PERIOD_W-1:0] div_rem;

  assign in_acc = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);

  // effective sweep length: zero reads as one, clamp to the channel count
  always_comb begin
    if (cis_r == 4'd0) begin
      nch = 6'd1;
    end else if (32'(cis_r) > CHANNELS) begin
      nch = 6'(CHANNELS);
    end else begin
      nch = {2'b00, cis_r};
    end
    pos0 = in_ch.block_start ? '0 : pos_r;
    if (6'(pos0) >= nch) begin
      pos0 = '0;
    end
    pos1  = 6'(pos0) + 6'd1;
    wrap  = pos1 >= nch;
    t_now = in_ch.block_start ? {1'b0, in_ch.block_time} : rt_r;
  end

  assign idx_ext  = {3'b000, in_ch.table_index};
  assign g_ext    = {2'b00, g_r};
  assign gi       = g_ext[GW-1:0];
  assign slot_ext = {1'b0, slot_r};
  assign slot_ok  = grp_open_r[gi] && (slot_ext < cnt_r) && (32'(slot_r) < SLOTS);
  assign k_last   = (k_r + 5'd1) == cnt_r;

  always_comb begin
    per_clamp = (in_ch.period_us == '0) ? PERIOD_W'(1) : in_ch.period_us;
    if (in_ch.slot_count == 5'd0) begin
      sc_clamp = 5'd1;
    end else if ({1'b0, in_ch.slot_count} > 6'(SLOTS)) begin
      sc_clamp = 5'(SLOTS);
    end else begin
      sc_clamp = in_ch.slot_count;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cis_r       <= 4'd1;
      sweep_per_r <= 20'd10000;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_CHANNELS_IN_SWEEP: cis_r       <= cfg_data[3:0];
        CFG_SWEEP_PERIOD_US:   sweep_per_r <= cfg_data;
        default:               ;
      endcase
    end
  end

  // channel and group tables
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        ch_slope_r[i]  <= '0;
        ch_offset_r[i] <= '0;
        ch_route_r[i]  <= '0;
      end
      for (int j = 0; j < GROUPS; j++) begin
        grp_end_r[j]   <= '0;
        grp_open_r[j]  <= 1'b0;
        grp_per_r[j]   <= PERIOD_W'(1);
        grp_slots_r[j] <= 5'd1;
      end
    end else begin
      if (in_acc && in_ch.opcode == OP_WR_CHAN && 32'(in_ch.table_index) < CHANNELS) begin
        ch_slope_r[idx_ext[CW-1:0]]  <= in_ch.slope;
        ch_offset_r[idx_ext[CW-1:0]] <= in_ch.intercept;
        ch_route_r[idx_ext[CW-1:0]]  <= {in_ch.target_group, in_ch.target_slot};
      end
      if (in_acc && in_ch.opcode == OP_WR_GROUP && 32'(in_ch.table_index) < GROUPS) begin
        grp_per_r[idx_ext[GW-1:0]]   <= per_clamp;
        grp_slots_r[idx_ext[GW-1:0]] <= sc_clamp;
      end
      if (state_r == ST_CLEAR) begin
        grp_end_r[gi]  <= end_r;
        grp_open_r[gi] <= 1'b1;
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      pos_r   <= '0;
      rt_r    <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc && in_ch.opcode == OP_SAMPLE) begin
            ch_r    <= pos0;
            count_r <= in_ch.raw_count;
            t_r     <= t_now;
            pos_r   <= wrap ? '0 : pos1[CW-1:0];
            rt_r    <= wrap ? t_now + TIME_W'(sweep_per_r) : t_now;
            state_r <= ST_LOOK;
          end
        end
        ST_LOOK: begin
          g_r     <= ch_route_r[ch_r][6:4];
          slot_r  <= ch_route_r[ch_r][3:0];
          state_r <= ST_RND;
        end
        ST_RND: begin
          per_r   <= grp_per_r[gi];
          end_r   <= grp_end_r[gi];
          cnt_r   <= grp_slots_r[gi];
          tag_r   <= grp_end_r[gi] - TIME_W'(grp_per_r[gi] >> 1);
          state_r <= ST_CHECK;
        end
        ST_CHECK: begin
          k_r <= '0;
          if (32'(g_r) >= GROUPS) begin
            state_r <= ST_IDLE;
          end else if (t_r > end_r) begin
            state_r <= grp_open_r[gi] ? ST_EMIT_RD : ST_DIV_GO;
          end else begin
            state_r <= ST_WRITE;
          end
        end
        ST_EMIT_RD: begin
          state_r <= ST_EMIT_SEND;
        end
        ST_EMIT_SEND: begin
          if (out_ch.ready) begin
            if (k_last) begin
              state_r <= ST_ADV;
            end else begin
              k_r     <= k_r + 5'd1;
              state_r <= ST_EMIT_RD;
            end
          end
        end
        ST_ADV: begin
          end_r   <= end_r + TIME_W'(per_r);
          state_r <= ST_NEXT;
        end
        ST_NEXT: begin
          k_r     <= '0;
          state_r <= (t_r > end_r) ? ST_DIV_GO : ST_CLEAR;
        end
        ST_DIV_GO: begin
          state_r <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (div_sts.done) begin
            end_r   <= t_r - TIME_W'(div_rem);
            state_r <= ST_CEIL;
          end
        end
        ST_CEIL: begin
          // round up to the next period multiple unless already on one
          if (div_rem != '0) begin
            end_r <= end_r + TIME_W'(per_r);
          end
          k_r     <= '0;
          state_r <= ST_CLEAR;
        end
        ST_CLEAR: begin
          k_r <= k_r + 5'd1;
          if (k_r == 5'(SLOTS - 1)) begin
            state_r <= ST_WRITE;
          end
        end
        ST_WRITE: begin
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // record memory port selection
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {gi, k_r[SW-1:0]};
    mem_wdata = '0;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (state_r == ST_WRITE && slot_ok) begin
      mem_we    = 1'b1;
      mem_waddr = {gi, slot_ext[SW-1:0]};
      mem_wdata = (count_r == MISSING_COUNT) ? 33'd0 : {1'b1, volts};
    end
  end

  assign mem_raddr = {gi, k_r[SW-1:0]};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[mem_raddr];
  end

  assign div_ctl.start = (state_r == ST_DIV_GO);

  astb_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (t_r),
    .divisor  (per_r),
    .sts      (div_sts),
    .rem      (div_rem)
  );

  astb_scale u_scale (
    .clk    (clk),
    .slope  (ch_slope_r[ch_r]),
    .offset (ch_offset_r[ch_r]),
    .count  (count_r),
    .volts  (volts)
  );

  assign out_ch.valid     = (state_r == ST_EMIT_SEND);
  assign out_ch.group     = g_r;
  assign out_ch.slot      = k_r[3:0];
  assign out_ch.valid_res = rd_data_r[32];
  assign out_ch.volts     = rd_data_r[32] ? rd_data_r[31:0] : 32'sd0;
  assign out_ch.time_tag  = tag_r[62:0];
  assign out_ch.last      = k_last;

  `ASTB_ASSERT_IMP(a_no_accept_while_out, in_ch.ready, !out_ch.valid)
  `ASTB_ASSERT_IMP(a_div_done_waited, div_sts.done, state_r == ST_DIV_WAIT)
  `ASTB_ASSERT_IMP(a_emit_in_record, out_ch.valid, k_r < cnt_r)
  `ASTB_ASSERT_IMP(a_write_open, mem_we && state_r == ST_WRITE, grp_open_r[gi])

endmodule
`default_nettype wire

// File: bench/tb.sv
// Self-checking bench for the sweep scaler / time binner top level.
// Depends on astb_pkg, the astb_in_if / astb_out_if interfaces and the top level of the RTL.
// Predicts every record word from its own model of the scaling and time binning.
`default_nettype none
module tb
  import astb_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int NCHAN = 8;
  localparam int NGRP  = 8;
  localparam int NSLOT = 16;

  typedef struct {
    logic [1:0]         op;
    logic [2:0]         idx;
    logic signed [15:0] cnt;
    logic               bstart;
    logic [62:0]        btime;
    logic signed [31:0] slope;
    logic signed [31:0] icpt;
    logic [2:0]         tgrp;
    logic [3:0]         tslot;
    logic [19:0]        per;
    logic [4:0]         scnt;
  } count_word_t;

  typedef struct {
    logic [2:0]         grp;
    logic [3:0]         slot;
    logic signed [31:0] volts;
    logic               vld;
    logic [62:0]        tag;
    logic               last;
  } record_word_t;

  logic clk, rst_n;
  logic cfg_we;
  logic [0:0] cfg_index;
  logic [19:0] cfg_data;

  astb_in_if in_ch();
  astb_out_if out_ch();

  adc_sweep_scaler_time_binner_top uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  // model state
  logic [3:0]  m_nch;
  logic [19:0] m_sweep_per;
  int unsigned m_pos;
  logic [63:0] m_time;
  logic [63:0] m_end [NGRP];
  bit          m_open [NGRP];
  logic [32:0] m_rec [NGRP*NSLOT];
  logic [31:0] m_slope [NCHAN];
  logic [31:0] m_icpt [NCHAN];
  logic [2:0]  m_rgrp [NCHAN];
  logic [3:0]  m_rslot [NCHAN];
  logic [19:0] m_gper [NGRP];
  logic [4:0]  m_gslots [NGRP];

  count_word_t  pending_words[$];
  record_word_t expected_words[$];
  int errors = 0;
  int words_in = 0;
  int words_out = 0;
  bit no_idle = 0;
  logic hold;

  task automatic report(input string msg);
    $display("mismatch @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic enqueue_word(input count_word_t w);
    pending_words = {pending_words, w};
  endtask

  task automatic expect_word(input record_word_t r);
    expected_words = {expected_words, r};
  endtask

  function automatic logic [31:0] scaled_volts(logic [31:0] sl, logic [31:0] off,
                                               logic signed [15:0] c);
    logic signed [63:0] p, q, s;
    p = 64'($signed(sl)) * 64'(c);
    q = (p + 64'sd32768) >>> 16;
    s = q + 64'($signed(off));
    if (s > 64'sd2147483647) s = 64'sd2147483647;
    if (s < -64'sd2147483648) s = -64'sd2147483648;
    return s[31:0];
  endfunction

  function automatic logic [63:0] ceil_mult(logic [63:0] t, logic [63:0] d);
    logic [63:0] q;
    q = t / d;
    if (t % d != 0) q++;
    return q * d;
  endfunction

  task automatic bin_word(input count_word_t w);
    int unsigned nch, ch, g, sl;
    logic [63:0] t, per;
    logic [62:0] tag;
    record_word_t r;
    case (w.op)
      OP_WR_CHAN: begin
        m_slope[w.idx] = w.slope;
        m_icpt[w.idx] = w.icpt;
        m_rgrp[w.idx] = w.tgrp;
        m_rslot[w.idx] = w.tslot;
      end
      OP_WR_GROUP: begin
        m_gper[w.idx] = (w.per == 0) ? 20'd1 : w.per;
        m_gslots[w.idx] = (w.scnt == 0) ? 5'd1 : (w.scnt > NSLOT) ? 5'(NSLOT) : w.scnt;
      end
      OP_SAMPLE: begin
        nch = m_nch;
        if (nch == 0) nch = 1;
        if (nch > NCHAN) nch = NCHAN;
        if (w.bstart) begin
          m_time = {1'b0, w.btime};
          m_pos = 0;
        end
        if (m_pos >= nch) m_pos = 0;
        ch = m_pos;
        t = m_time;
        g = m_rgrp[ch];
        sl = m_rslot[ch];
        per = 64'(m_gper[g]);
        if (t > m_end[g]) begin
          if (m_open[g]) begin
            tag = 63'(m_end[g] - (per >> 1));
            for (int k = 0; k < m_gslots[g]; k++) begin
              r.grp = 3'(g);
              r.slot = 4'(k);
              r.vld = m_rec[g*NSLOT+k][32];
              r.volts = r.vld ? m_rec[g*NSLOT+k][31:0] : 32'd0;
              r.tag = tag;
              r.last = (k + 1 == m_gslots[g]);
              expect_word(r);
            end
            m_end[g] += per;
            if (t > m_end[g]) m_end[g] = ceil_mult(t, per);
          end else begin
            m_end[g] = ceil_mult(t, per);
          end
          for (int k = 0; k < NSLOT; k++) m_rec[g*NSLOT+k] = '0;
          m_open[g] = 1;
        end
        if (m_open[g] && sl < m_gslots[g])
          m_rec[g*NSLOT+sl] = (w.cnt == MISSING_COUNT) ? 33'd0 :
                              {1'b1, scaled_volts(m_slope[ch], m_icpt[ch], w.cnt)};
        m_pos++;
        if (m_pos >= nch) begin
          m_pos = 0;
          m_time += 64'(m_sweep_per);
        end
      end
      default: ;
    endcase
  endtask

  function automatic int unsigned pick_gap();
    if (no_idle || $urandom_range(0, 9) < 6) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver
  int unsigned in_gap = 0;
  always @(posedge clk) begin
    count_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        w.op = in_ch.opcode; w.idx = in_ch.table_index; w.cnt = in_ch.raw_count;
        w.bstart = in_ch.block_start; w.btime = in_ch.block_time;
        w.slope = in_ch.slope; w.icpt = in_ch.intercept; w.tgrp = in_ch.target_group;
        w.tslot = in_ch.target_slot; w.per = in_ch.period_us; w.scnt = in_ch.slot_count;
        bin_word(w);
        words_in++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_gap--;
          in_ch.valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          w = pending_words.pop_front();
          in_ch.opcode <= w.op; in_ch.table_index <= w.idx; in_ch.raw_count <= w.cnt;
          in_ch.block_start <= w.bstart; in_ch.block_time <= w.btime;
          in_ch.slope <= w.slope; in_ch.intercept <= w.icpt;
          in_ch.target_group <= w.tgrp; in_ch.target_slot <= w.tslot;
          in_ch.period_us <= w.per; in_ch.slot_count <= w.scnt;
          in_ch.valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  int unsigned out_stall = 0;
  always @(posedge clk) begin
    record_word_t e;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        words_out++;
        if (expected_words.size() == 0) begin
          report($sformatf("unexpected word group %0d slot %0d", out_ch.group, out_ch.slot));
        end else begin
          e = expected_words.pop_front();
          if (out_ch.group !== e.grp)
            report($sformatf("group %0d, want %0d", out_ch.group, e.grp));
          if (out_ch.slot !== e.slot)
            report($sformatf("slot %0d, want %0d", out_ch.slot, e.slot));
          if (out_ch.volts !== e.volts)
            report($sformatf("volts %h, want %h", out_ch.volts, e.volts));
          if (out_ch.valid_res !== e.vld)
            report($sformatf("valid_res %b, want %b", out_ch.valid_res, e.vld));
          if (out_ch.time_tag !== e.tag)
            report($sformatf("time_tag %0d, want %0d", out_ch.time_tag, e.tag));
          if (out_ch.last !== e.last)
            report($sformatf("last %b, want %b", out_ch.last, e.last));
        end
      end
      if (out_stall > 0) out_stall--;
      else if ($urandom_range(0, 3) == 0) out_stall = pick_gap();
      out_ch.ready <= !hold && (out_stall == 0);
    end
  end

  // long hold-off on the result side while counts are still offered
  initial begin
    hold = 1'b0;
    wait (words_in >= 40);
    @(posedge clk);
    hold <= 1'b1;
    repeat (600) @(posedge clk);
    hold <= 1'b0;
  end

  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic count_word_t noise_word();
    count_word_t w;
    w.op = 2'($urandom); w.idx = 3'($urandom); w.cnt = 16'($urandom);
    w.bstart = 1'($urandom); w.btime = {31'($urandom), 32'($urandom)};
    w.slope = $urandom; w.icpt = $urandom; w.tgrp = 3'($urandom);
    w.tslot = 4'($urandom); w.per = 20'($urandom); w.scnt = 5'($urandom);
    return w;
  endfunction

  task automatic push_sample(input logic signed [15:0] c, input logic bs,
                             input logic [62:0] bt);
    count_word_t w;
    w = noise_word();
    w.op = OP_SAMPLE; w.cnt = c; w.bstart = bs; w.btime = bt;
    enqueue_word(w);
  endtask

  task automatic push_chan(input logic [2:0] i, input logic [31:0] sl, input logic [31:0] off,
                           input logic [2:0] g, input logic [3:0] s);
    count_word_t w;
    w = noise_word();
    w.op = OP_WR_CHAN; w.idx = i; w.slope = sl; w.icpt = off; w.tgrp = g; w.tslot = s;
    enqueue_word(w);
  endtask

  task automatic push_group(input logic [2:0] i, input logic [19:0] p, input logic [4:0] sc);
    count_word_t w;
    w = noise_word();
    w.op = OP_WR_GROUP; w.idx = i; w.per = p; w.scnt = sc;
    enqueue_word(w);
  endtask

  task automatic cfg_write(input logic [0:0] i, input logic [19:0] d);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= i;
    cfg_data <= d;
    if (i == CFG_CHANNELS_IN_SWEEP) m_nch = d[3:0];
    else m_sweep_per = d;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // drain everything, then leave time for a count that sends nothing
  task automatic settle();
    while (pending_words.size() > 0 || in_ch.valid || expected_words.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    count_word_t w;
    int unsigned nsw, k, ph;
    logic [19:0] sp;
    logic [31:0] gp;
    in_ch.valid = 1'b0; in_ch.opcode = '0; in_ch.table_index = '0; in_ch.raw_count = '0;
    in_ch.block_start = 1'b0; in_ch.block_time = '0; in_ch.slope = '0; in_ch.intercept = '0;
    in_ch.target_group = '0; in_ch.target_slot = '0; in_ch.period_us = '0;
    in_ch.slot_count = '0; out_ch.ready = 1'b0;
    cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    m_nch = 4'd1; m_sweep_per = 20'd10000; m_pos = 0; m_time = '0;
    for (int i = 0; i < NGRP; i++) begin
      m_end[i] = '0; m_open[i] = 0; m_gper[i] = 20'd1; m_gslots[i] = 5'd1;
    end
    for (int i = 0; i < NGRP*NSLOT; i++) m_rec[i] = '0;
    for (int i = 0; i < NCHAN; i++) begin
      m_slope[i] = '0; m_icpt[i] = '0; m_rgrp[i] = '0; m_rslot[i] = '0;
    end
    rst_n = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // directed: a group never opened, unused opcode, table limits, saturation
    push_sample(16'sd100, 1'b0, '0);
    w = noise_word(); w.op = OP_UNUSED; enqueue_word(w);
    push_chan(3'd0, 32'h0001_0000, 32'd0, 3'd1, 4'd0);
    push_chan(3'd7, 32'h7fff_ffff, 32'h8000_0000, 3'd7, 4'd15);
    push_group(3'd1, 20'd0, 5'd0);
    push_group(3'd1, 20'd25000, 5'd31);
    push_group(3'd2, 20'd5, 5'd3);
    push_sample(16'sd1234, 1'b0, '0);
    push_sample(MISSING_COUNT, 1'b0, '0);
    push_sample(16'sd32767, 1'b0, '0);
    push_chan(3'd0, 32'h7fff_ffff, 32'h7fff_ffff, 3'd1, 4'd15);
    push_sample(16'sd32767, 1'b0, '0);
    push_chan(3'd0, 32'h8000_0000, 32'h8000_0000, 3'd1, 4'd3);
    push_sample(16'sd32767, 1'b0, '0);
    push_sample(-16'sd32767, 1'b0, '0);
    push_sample(16'sd7, 1'b1, 63'h7fff_ffff_ffff_ffff);
    push_group(3'd1, 20'hfffff, 5'd2);
    push_chan(3'd0, 32'h0000_8000, 32'h0001_0000, 3'd1, 4'd15);
    push_sample(16'sd5, 1'b0, '0);
    push_chan(3'd0, 32'h0000_8000, 32'h0001_0000, 3'd2, 4'd2);
    push_sample(16'sd1, 1'b1, '0);
    push_sample(-16'sd1, 1'b0, '0);
    push_sample(16'sd3, 1'b0, '0);
    settle();

    // random phases, each under its own register setting
    ph = 0;
    while (words_in < 95 && ph < 30) begin
      case (ph)
        0: begin cfg_write(CFG_CHANNELS_IN_SWEEP, 20'd8); cfg_write(CFG_SWEEP_PERIOD_US, 20'd1); end
        1: begin cfg_write(CFG_CHANNELS_IN_SWEEP, 20'd1); cfg_write(CFG_SWEEP_PERIOD_US, 20'd1000000); end
        2: begin cfg_write(CFG_CHANNELS_IN_SWEEP, 20'hfffff); cfg_write(CFG_SWEEP_PERIOD_US, 20'hfffff); end
        3: begin cfg_write(CFG_CHANNELS_IN_SWEEP, 20'd0); cfg_write(CFG_SWEEP_PERIOD_US, 20'd0); end
        default: begin
          cfg_write(CFG_CHANNELS_IN_SWEEP, 20'($urandom_range(1, 8)));
          cfg_write(CFG_SWEEP_PERIOD_US, 20'($urandom_range(1, 50000)));
        end
      endcase
      no_idle = ($urandom_range(0, 3) == 0);
      sp = (m_sweep_per == 0) ? 20'd1 : m_sweep_per;
      for (int i = 0; i < 3; i++)
        push_chan(3'($urandom), $urandom, $urandom, 3'($urandom_range(0, 3)),
                  4'($urandom_range(0, 7)));
      for (int i = 0; i < 2; i++) begin
        gp = 32'(sp) * $urandom_range(1, 3);
        if (gp > 32'hfffff) gp = 32'(sp);
        push_group(3'($urandom_range(0, 3)), gp[19:0], 5'($urandom_range(4, 16)));
      end
      push_sample(16'($urandom), 1'b1,
                  ($urandom_range(0, 3) == 0) ? {31'($urandom), 32'($urandom)} :
                                                63'($urandom_range(0, 100000)));
      nsw = $urandom_range(10, 22);
      for (k = 0; k < nsw; k++) begin
        if ($urandom_range(0, 9) == 0) enqueue_word(noise_word());
        else push_sample(($urandom_range(0, 9) == 0) ? MISSING_COUNT : 16'($urandom),
                         1'b0, '0);
      end
      settle();
      ph++;
    end

    if (errors == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end
endmodule
`default_nettype wire

// File: sim.f
+incdir+rtl/core
rtl/core/astb_pkg.sv
rtl/core/astb_ifs.sv
rtl/core/astb_rem_unit.sv
rtl/core/astb_scale.sv
rtl/core/adc_sweep_scaler_time_binner_top.sv
bench/tb.sv
